>>> sv/usd_pkg.sv
// usd_pkg: word types, status codes and decoder state for the utf-8 stream decoder
`timescale 1ns / 1ps

package usd_pkg;

    // status codes carried with each result word
    localparam logic [1:0] STATUS_COMPLETE  = 2'd0;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
    localparam logic [1:0] STATUS_END       = 2'd2;

    // byte values that steer lead byte decoding
    localparam logic [7:0] FACE_ESCAPE = 8'h0A;
    localparam logic [7:0] LEAD_CONT   = 8'h80;
    localparam logic [7:0] LEAD_TWO    = 8'hC0;
    localparam logic [7:0] LEAD_THREE  = 8'hE0;
    localparam logic [7:0] LEAD_FOUR   = 8'hF0;
    localparam logic [7:0] LEAD_BAD    = 8'hF8;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00003F;

    // one input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } usd_in_word_t;

    // one result word
    typedef struct packed {
        logic [20:0] code_point;
        logic [1:0]  status;
        logic [15:0] char_count;
        logic        last_of_text;
    } usd_out_word_t;

    // decoder state carried between bytes
    typedef struct packed {
        logic [3:0]  bytes_left;
        logic        in_face_skip;
        logic [20:0] code_accum;
        logic [15:0] char_total;
    } usd_state_t;

    localparam usd_state_t STATE_RESET = '{
        bytes_left:   4'd0,
        in_face_skip: 1'b0,
        code_accum:   21'd0,
        char_total:   16'd0
    };

endpackage

>>> sv/usd_step.sv
// usd_step: per-byte decode and state update for the utf-8 stream decoder
`timescale 1ns / 1ps

module usd_step #(
    parameter int FACE_LEN   = 4,
    parameter int COUNT_BITS = 16
) (
    input  usd_pkg::usd_state_t    state,
    input  usd_pkg::usd_in_word_t  in_word,
    output usd_pkg::usd_state_t    state_next,
    output logic                   emit,
    output usd_pkg::usd_out_word_t out_word
);
    import usd_pkg::*;

    localparam int          CNT_W     = (COUNT_BITS < 16) ? COUNT_BITS : 16;
    localparam logic [15:0] COUNT_MAX = 16'((32'd1 << CNT_W) - 32'd1);
    localparam logic [3:0]  FACE_SKIP = 4'(FACE_LEN - 1);

    usd_state_t  nxt;
    logic        done;
    logic [3:0]  left_dec;
    logic [15:0] count_inc;
    logic [7:0]  b;

    assign b        = in_word.data_byte;
    assign left_dec = state.bytes_left - 4'd1;

    // symbol decode: lead byte or following byte
    always_comb
    begin
        nxt  = state;
        done = 1'b0;
        if (state.bytes_left == 4'd0)
        begin
            priority if (b == FACE_ESCAPE)
            begin
                nxt.bytes_left   = FACE_SKIP;
                nxt.in_face_skip = (FACE_SKIP != 4'd0);
            end
            else if (b < LEAD_CONT)
            begin
                nxt.code_accum = {13'd0, b};
                done           = 1'b1;
            end
            else if (b < LEAD_TWO)
            begin
                // stray continuation, nothing to do
            end
            else if (b < LEAD_THREE)
            begin
                nxt.code_accum = {16'd0, b[4:0]};
                nxt.bytes_left = 4'd1;
            end
            else if (b < LEAD_FOUR)
            begin
                nxt.code_accum = {17'd0, b[3:0]};
                nxt.bytes_left = 4'd2;
            end
            else if (b < LEAD_BAD)
            begin
                nxt.code_accum = {18'd0, b[2:0]};
                nxt.bytes_left = 4'd3;
            end
            else
            begin
                // 0xf8 and above, nothing to do
            end
        end
        else
        begin
            nxt.bytes_left = left_dec;
            if (state.in_face_skip)
            begin
                if (left_dec == 4'd0)
                begin
                    nxt.in_face_skip = 1'b0;
                end
            end
            else
            begin
                nxt.code_accum = {state.code_accum[14:0], b[5:0]};
                done           = (left_dec == 4'd0);
            end
        end
    end

    // saturating character count
    assign count_inc = (nxt.char_total != COUNT_MAX) ? nxt.char_total + 16'd1
                                                     : nxt.char_total;

    // result word and end of text handling
    always_comb
    begin
        emit       = 1'b0;
        out_word   = '{code_point: 21'd0, status: STATUS_END,
                       char_count: nxt.char_total, last_of_text: 1'b0};
        state_next = nxt;
        if (done)
        begin
            emit                  = 1'b1;
            out_word.code_point   = nxt.code_accum;
            out_word.status       = STATUS_COMPLETE;
            out_word.char_count   = count_inc;
            out_word.last_of_text = in_word.end_of_text;
            state_next.char_total = count_inc;
            if (in_word.end_of_text)
            begin
                state_next = STATE_RESET;
            end
        end
        else if (in_word.end_of_text)
        begin
            emit                  = 1'b1;
            out_word.last_of_text = 1'b1;
            if (nxt.bytes_left != 4'd0 && !nxt.in_face_skip)
            begin
                out_word.code_point = REPLACEMENT_CP;
                out_word.status     = STATUS_TRUNCATED;
                out_word.char_count = count_inc;
            end
            state_next = STATE_RESET;
        end
    end

endmodule

>>> sv/utf8_stream_decoder.sv
// utf8_stream_decoder: top level, input register, decode step and result register
//
//  channel | direction | handshake              | payload
//  byte    | in        | byte_valid, byte_stall | byte_word (data_byte, end_of_text)
//  char    | out       | char_valid, char_stall | char_word (code_point, status,
//          |           |                        |  char_count, last_of_text)
//
// one byte per cycle sustained while the result side does not stall; a byte passes
// through the input register and then the result register
// the decode state is updated in the same cycle that a byte moves to the result
// register, so the per-byte update is a single short pass
// rst_n clears the control state and the decode state; no clearing pass
// a stall on the result side holds both registers and stalls the byte side
// once the input register is full
`timescale 1ns / 1ps

module utf8_stream_decoder #(
    parameter int FACE_LEN   = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  usd_pkg::usd_in_word_t  byte_word,
    output logic                   char_valid,
    input  logic                   char_stall,
    output usd_pkg::usd_out_word_t char_word
);
    import usd_pkg::*;

    logic          in_valid_reg;
    usd_in_word_t  in_word_reg;
    usd_state_t    state_reg;
    usd_state_t    state_next;
    logic          out_valid_reg;
    usd_out_word_t out_word_reg;
    logic          emit;
    usd_out_word_t step_word;
    logic          advance;

    // result register free or draining this cycle
    assign advance    = !out_valid_reg || !char_stall;
    assign byte_stall = in_valid_reg && !advance;

    assign char_valid = out_valid_reg;
    assign char_word  = out_word_reg;

    usd_step #(
        .FACE_LEN   (FACE_LEN),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .state      (state_reg),
        .in_word    (in_word_reg),
        .state_next (state_next),
        .emit       (emit),
        .out_word   (step_word)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            in_word_reg <= byte_word;
        end
    end

    // decode state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && emit;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && emit)
        begin
            out_word_reg <= step_word;
        end
    end

endmodule

>>> sv/usd_checker.sv
// usd_checker: port-level assertions for the utf-8 stream decoder, with its bind
`timescale 1ns / 1ps

module usd_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   byte_valid,
    input logic                   byte_stall,
    input usd_pkg::usd_in_word_t  byte_word,
    input logic                   char_valid,
    input logic                   char_stall,
    input usd_pkg::usd_out_word_t char_word
);
    import usd_pkg::*;

    // a stalled result word stays offered and unchanged
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid && $stable(char_word))
        else $error("result word dropped or changed while stalled");

    // a stalled byte word stays offered and unchanged
    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_word))
        else $error("byte word dropped or changed while stalled");

    // end-only word carries no character and closes the text
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_word.status == STATUS_END |->
            char_word.code_point == 21'd0 && char_word.last_of_text)
        else $error("bad end-only word");

    // truncated character gives the replacement and closes the text
    a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_word.status == STATUS_TRUNCATED |->
            char_word.code_point == REPLACEMENT_CP && char_word.last_of_text &&
            char_word.char_count != 16'd0)
        else $error("bad truncated word");

    // a completed character is always counted
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_word.status == STATUS_COMPLETE |->
            char_word.char_count != 16'd0)
        else $error("completed character with zero count");

endmodule

bind utf8_stream_decoder usd_checker u_usd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_word  (char_word)
);

>>> tb/sv/tb_utf8_stream_decoder.sv
// tb_utf8_stream_decoder: self-checking testbench for the utf-8 stream decoder
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;

    import usd_pkg::*;

    localparam int FACE_LEN     = 4;
    localparam int COUNT_BITS   = 16;
    localparam int COUNT_MAX    = (COUNT_BITS >= 16) ? 16'hFFFF : (1 << COUNT_BITS) - 1;
    localparam int RANDOM_BYTES = 1480;
    localparam int BURST_BYTES  = 40;

    // one byte waiting to be sent, with its lead-in gap
    typedef struct {
        usd_in_word_t word;
        int unsigned  gap;
        bit           drain;
    } byte_item_t;

    logic          clk        = 1'b0;
    logic          rst_n      = 1'b0;
    logic          byte_valid = 1'b0;
    logic          byte_stall;
    usd_in_word_t  byte_word  = '0;
    logic          char_valid;
    logic          char_stall = 1'b0;
    usd_out_word_t char_word;

    byte_item_t    pending_bytes[$];
    usd_out_word_t expected_chars[$];
    usd_state_t    dec_state = STATE_RESET;

    int unsigned   gap_left;
    bit            gap_armed;
    int unsigned   stall_left;
    int unsigned   calm_left;
    bit            tx_calm;
    bit            rx_quiet;
    int unsigned   bytes_sent;
    int unsigned   texts_sent;
    int unsigned   chars_seen;
    int unsigned   mismatch_count;

    utf8_stream_decoder #(
        .FACE_LEN   (FACE_LEN),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // decode one accepted byte and queue the result word it gives, if any
    task automatic decode_byte(input usd_in_word_t w);
        usd_out_word_t r;
        logic          done;
        logic [7:0]    b;
        b    = w.data_byte;
        done = 1'b0;
        r    = '0;
        if (dec_state.bytes_left == 0)
        begin
            if (b == FACE_ESCAPE)
            begin
                dec_state.bytes_left   = 4'(FACE_LEN - 1);
                dec_state.in_face_skip = (dec_state.bytes_left != 0);
            end
            else if (b < LEAD_CONT)
            begin
                dec_state.code_accum = {13'd0, b};
                done                 = 1'b1;
            end
            else if (b < LEAD_TWO)
            begin
                // stray continuation, dropped
            end
            else if (b < LEAD_THREE)
            begin
                dec_state.code_accum = {16'd0, b[4:0]};
                dec_state.bytes_left = 4'd1;
            end
            else if (b < LEAD_FOUR)
            begin
                dec_state.code_accum = {17'd0, b[3:0]};
                dec_state.bytes_left = 4'd2;
            end
            else if (b < LEAD_BAD)
            begin
                dec_state.code_accum = {18'd0, b[2:0]};
                dec_state.bytes_left = 4'd3;
            end
        end
        else
        begin
            dec_state.bytes_left = dec_state.bytes_left - 4'd1;
            if (dec_state.in_face_skip)
            begin
                if (dec_state.bytes_left == 0)
                    dec_state.in_face_skip = 1'b0;
            end
            else
            begin
                dec_state.code_accum = {dec_state.code_accum[14:0], b[5:0]};
                if (dec_state.bytes_left == 0)
                    done = 1'b1;
            end
        end

        // a completed character, or the closing word at end of text
        if (done || w.end_of_text)
        begin
            if (done)
            begin
                if (int'(dec_state.char_total) < COUNT_MAX)
                    dec_state.char_total = dec_state.char_total + 16'd1;
                r.code_point = dec_state.code_accum;
                r.status     = STATUS_COMPLETE;
            end
            else if (dec_state.bytes_left != 0 && !dec_state.in_face_skip)
            begin
                if (int'(dec_state.char_total) < COUNT_MAX)
                    dec_state.char_total = dec_state.char_total + 16'd1;
                r.code_point = REPLACEMENT_CP;
                r.status     = STATUS_TRUNCATED;
            end
            else
            begin
                r.code_point = '0;
                r.status     = STATUS_END;
            end
            r.char_count   = dec_state.char_total;
            r.last_of_text = w.end_of_text;
            expected_chars.push_back(r);
            if (w.end_of_text)
                dec_state = STATE_RESET;
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic eot, input bit drain);
        byte_item_t item;
        item.word.data_byte   = b;
        item.word.end_of_text = eot;
        item.gap              = tx_calm ? 0 : $urandom_range(0, 9);
        item.drain            = drain;
        pending_bytes.push_back(item);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || byte_valid || expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // byte side driver: gap, optional drain, then hold the word until taken
    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        byte_item_t head;
        logic       nxt_valid;
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_word  <= '0;
            gap_armed  = 1'b0;
            gap_left   = 0;
        end
        else
        begin
            nxt_valid = byte_valid;
            if (byte_valid && !byte_stall)
            begin
                decode_byte(byte_word);
                bytes_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_bytes.size() != 0)
            begin
                head = pending_bytes[0];
                if (!gap_armed)
                begin
                    gap_left  = head.gap;
                    gap_armed = 1'b1;
                end
                if (gap_left != 0)
                    gap_left--;
                else if (!(head.drain && expected_chars.size() != 0))
                begin
                    nxt_valid = 1'b1;
                    byte_word <= head.word;
                    void'(pending_bytes.pop_front());
                    gap_armed = 1'b0;
                end
            end
            byte_valid <= nxt_valid;
        end
    end

    // result side monitor: check each word taken, then draw the next stall
    always @(posedge clk or negedge rst_n)
    begin : char_monitor
        usd_out_word_t want;
        if (!rst_n)
        begin
            char_stall <= 1'b0;
            stall_left = 0;
            calm_left  = 0;
        end
        else
        begin
            if (char_valid && !char_stall)
            begin
                chars_seen++;
                if (expected_chars.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: cp=%h st=%0d cnt=%0d last=%0d",
                                 char_word.code_point, char_word.status,
                                 char_word.char_count, char_word.last_of_text);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_word.code_point !== want.code_point ||
                        char_word.status !== want.status ||
                        char_word.char_count !== want.char_count ||
                        char_word.last_of_text !== want.last_of_text)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch: want cp=%h st=%0d cnt=%0d last=%0d",
                                     want.code_point, want.status, want.char_count,
                                     want.last_of_text);
                            $display("          got  cp=%h st=%0d cnt=%0d last=%0d",
                                     char_word.code_point, char_word.status,
                                     char_word.char_count, char_word.last_of_text);
                        end
                    end
                end
                stall_left = (rx_quiet || calm_left != 0) ? 0 : $urandom_range(0, 9);
            end
            // occasional stretches with no stalls
            if (calm_left != 0)
                calm_left--;
            else if ($urandom_range(0, 199) == 0)
                calm_left = $urandom_range(20, 100);
            char_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        logic [7:0]  sym[$];
        logic [7:0]  b;
        int unsigned counted;
        int unsigned n_sym;
        int unsigned kind;
        int unsigned nc;
        int unsigned cut;
        bit          first;
        bit          drain;
        counted  = 0;
        tx_calm  = 1'b0;
        rx_quiet = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // lead byte extremes, all lead classes, broken bytes, skipped face escape
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h7F, 1'b0, 1'b0);
        queue_byte(8'hC2, 1'b0, 1'b0);
        queue_byte(8'h80, 1'b0, 1'b0);
        queue_byte(8'hDF, 1'b0, 1'b0);
        queue_byte(8'hBF, 1'b0, 1'b0);
        queue_byte(8'hEF, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hF7, 1'b0, 1'b0);
        queue_byte(8'hBF, 1'b0, 1'b0);
        queue_byte(8'hBF, 1'b0, 1'b0);
        queue_byte(8'hBF, 1'b0, 1'b0);
        queue_byte(8'h80, 1'b0, 1'b0);
        queue_byte(8'hF8, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(FACE_ESCAPE, 1'b0, 1'b0);
        queue_byte(8'hC3, 1'b0, 1'b0);
        queue_byte(8'h41, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        // end of text completes a character
        queue_byte(8'h41, 1'b1, 1'b0);
        // truncated character at end of text
        queue_byte(8'hE2, 1'b0, 1'b1);
        queue_byte(8'h82, 1'b1, 1'b0);
        // face escape still open at end of text
        queue_byte(FACE_ESCAPE, 1'b0, 1'b0);
        queue_byte(8'h01, 1'b1, 1'b0);
        // broken byte as the last byte
        queue_byte(8'hBF, 1'b1, 1'b0);
        texts_sent = 4;

        // random texts, mostly well-formed symbols with random content
        while (counted < RANDOM_BYTES)
        begin
            n_sym   = $urandom_range(1, 24);
            tx_calm = ($urandom_range(0, 3) == 0);
            drain   = (texts_sent % 10 == 0);
            first   = 1'b1;
            for (int unsigned s = 0; s < n_sym; s++)
            begin
                sym.delete();
                kind = $urandom_range(0, 99);
                nc   = 0;
                if (kind < 35)
                begin
                    b = 8'($urandom_range(0, 127));
                    if (b == FACE_ESCAPE)
                        b = 8'h20;
                end
                else if (kind < 55)
                begin
                    b  = LEAD_TWO | 8'($urandom_range(0, 31));
                    nc = 1;
                end
                else if (kind < 70)
                begin
                    b  = LEAD_THREE | 8'($urandom_range(0, 15));
                    nc = 2;
                end
                else if (kind < 82)
                begin
                    b  = LEAD_FOUR | 8'($urandom_range(0, 7));
                    nc = 3;
                end
                else if (kind < 90)
                begin
                    b  = FACE_ESCAPE;
                    nc = FACE_LEN - 1;
                end
                else if (kind < 96)
                    b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                                    : 8'($urandom_range(8'hF8, 8'hFF));
                else
                    b = 8'($urandom_range(0, 255));
                sym.push_back(b);
                for (int unsigned k = 0; k < nc; k++)
                    sym.push_back(($urandom_range(0, 3) == 0)
                                  ? 8'($urandom_range(0, 255))
                                  : (LEAD_CONT | 8'($urandom_range(0, 63))));
                // the last symbol is sometimes cut short by the end of text
                cut = sym.size();
                if (s == n_sym - 1 && sym.size() > 1 && $urandom_range(0, 3) == 0)
                    cut = $urandom_range(1, sym.size() - 1);
                for (int unsigned k = 0; k < cut; k++)
                begin
                    queue_byte(sym[k], (s == n_sym - 1) && (k == cut - 1), drain && first);
                    first = 1'b0;
                    counted++;
                end
            end
            texts_sent++;
        end

        // one text sent back to back with no stalls on either side
        wait_drained();
        rx_quiet = 1'b1;
        tx_calm  = 1'b1;
        for (int unsigned k = 0; k < BURST_BYTES; k++)
        begin
            b = 8'($urandom_range(0, 127));
            if (b == FACE_ESCAPE)
                b = 8'h20;
            queue_byte(b, 1'b0, 1'b0);
        end
        queue_byte(8'hC3, 1'b0, 1'b0);
        queue_byte(8'hA9, 1'b0, 1'b0);
        queue_byte(8'hE2, 1'b1, 1'b0);
        wait_drained();
        rx_quiet = 1'b0;
        tx_calm  = 1'b0;
        // count starts again after the burst
        queue_byte(8'h5A, 1'b1, 1'b1);
        texts_sent += 2;

        wait_drained();
        repeat (8) @(posedge clk);
        if (expected_chars.size() != 0)
            mismatch_count += expected_chars.size();
        $display("sent %0d bytes in %0d texts, checked %0d result words, %0d mismatches",
                 bytes_sent, texts_sent, chars_seen, mismatch_count);
        $display("covered all lead classes, broken bytes, face escapes, truncation and bursts");
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hang guard
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
sv/usd_pkg.sv
sv/usd_step.sv
sv/utf8_stream_decoder.sv
sv/usd_checker.sv
tb/sv/tb_utf8_stream_decoder.sv
